// ----- sv/qmvn_pkg.sv -----
// Shared types and constants for the quad mesh vertex normal block.
// Used by the channel interfaces and every module of the block.
package qmvn_pkg;

  localparam int IdxW     = 10;
  localparam int PosW     = 16;
  localparam int NrmW     = 16;
  localparam int CntW     = 11;
  localparam int FnW      = 35;
  localparam int SumW     = 48;
  localparam int MulW     = 31;
  localparam int ProdW    = 62;
  localparam int RootW    = 31;
  localparam int NumW     = 46;
  localparam int DenW     = 32;
  localparam int QuotW    = 17;
  localparam int MaxQuads = 1024;

  localparam logic [1:0] OP_LOAD_VERTEX = 2'd0;
  localparam logic [1:0] OP_LOAD_QUAD   = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;
  localparam logic [1:0] OP_UNUSED      = 2'd3;

  localparam logic [NrmW-1:0] UNIT_ONE = 16'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VRD,
    ST_XMUL,
    ST_QWR,
    ST_WALK,
    ST_ABS,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

endpackage

// ----- sv/qmvn_if.sv -----
// Valid/ready channel interfaces for input words, result words and the config port.
// Depends on qmvn_pkg for field widths.
interface qmvn_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [qmvn_pkg::IdxW-1:0]     index;
  logic signed [qmvn_pkg::PosW-1:0] pos_x;
  logic signed [qmvn_pkg::PosW-1:0] pos_y;
  logic signed [qmvn_pkg::PosW-1:0] pos_z;
  logic [qmvn_pkg::IdxW-1:0]     corner_a;
  logic [qmvn_pkg::IdxW-1:0]     corner_b;
  logic [qmvn_pkg::IdxW-1:0]     corner_c;
  logic [qmvn_pkg::IdxW-1:0]     corner_d;
  modport source (output valid, operation, index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, corner_d, input ready);
  modport sink (input valid, operation, index, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

interface qmvn_out_if;
  logic                             valid;
  logic                             ready;
  logic [qmvn_pkg::IdxW-1:0]        vertex_index;
  logic signed [qmvn_pkg::NrmW-1:0] normal_x;
  logic signed [qmvn_pkg::NrmW-1:0] normal_y;
  logic signed [qmvn_pkg::NrmW-1:0] normal_z;
  logic                             zero_length;
  modport source (output valid, vertex_index, normal_x, normal_y, normal_z,
                  zero_length, input ready);
  modport sink (input valid, vertex_index, normal_x, normal_y, normal_z,
                zero_length, output ready);
endinterface

interface qmvn_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [qmvn_pkg::CntW-1:0] quad_count;
  modport source (output valid, quad_count, input ready);
  modport sink (input valid, quad_count, output ready);
endinterface

// ----- sv/qmvn_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on qmvn_pkg for operand widths.
module qmvn_mul (
  input  logic                               clk,
  input  logic signed [qmvn_pkg::MulW-1:0]   a,
  input  logic signed [qmvn_pkg::MulW-1:0]   b,
  output logic signed [qmvn_pkg::ProdW-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ----- sv/qmvn_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
// Depends on qmvn_pkg for widths.
module qmvn_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qmvn_pkg::ProdW-1:0]    radicand,
  output logic                          done_r,
  output logic [qmvn_pkg::RootW-1:0]    root_r
);

  logic [qmvn_pkg::ProdW-1:0] rad_r;
  logic [qmvn_pkg::RootW+1:0] rem_r;
  logic [4:0]                 cnt_r;
  logic                       busy_r;
  logic [qmvn_pkg::RootW+1:0] rem_t;
  logic [qmvn_pkg::RootW+1:0] trial;

  assign rem_t = {rem_r[qmvn_pkg::RootW-1:0], rad_r[qmvn_pkg::ProdW-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[qmvn_pkg::ProdW-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem_r  <= rem_t - trial;
          root_r <= {root_r[qmvn_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_t;
          root_r <= {root_r[qmvn_pkg::RootW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(qmvn_pkg::RootW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/qmvn_div.sv -----
// Restoring divider producing one quotient bit per cycle.
// Depends on qmvn_pkg; the quotient is known to fit QuotW bits.
module qmvn_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qmvn_pkg::NumW-1:0]     num,
  input  logic [qmvn_pkg::DenW-1:0]     den,
  output logic                          done_r,
  output logic [qmvn_pkg::QuotW-1:0]    quot_r
);

  logic [qmvn_pkg::DenW:0]        rem_r;
  logic [qmvn_pkg::DenW-1:0]      den_r;
  logic [qmvn_pkg::QuotW-1:0]     low_r;
  logic [4:0]                     cnt_r;
  logic                           busy_r;
  logic [qmvn_pkg::DenW:0]        t;

  assign t = {rem_r[qmvn_pkg::DenW-1:0], low_r[qmvn_pkg::QuotW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        rem_r  <= (qmvn_pkg::DenW+1)'(num[qmvn_pkg::NumW-1:qmvn_pkg::QuotW]);
        low_r  <= num[qmvn_pkg::QuotW-1:0];
        den_r  <= den;
        quot_r <= '0;
      end else if (busy_r) begin
        low_r <= {low_r[qmvn_pkg::QuotW-2:0], 1'b0};
        if (t >= {1'b0, den_r}) begin
          rem_r  <= t - {1'b0, den_r};
          quot_r <= {quot_r[qmvn_pkg::QuotW-2:0], 1'b1};
        end else begin
          rem_r  <= t;
          quot_r <= {quot_r[qmvn_pkg::QuotW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(qmvn_pkg::QuotW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/quad_mesh_vertex_normals.sv -----
// Top level: sequencer, vertex and quad memories, output register.
// Depends on qmvn_pkg, qmvn_if, qmvn_mul, qmvn_sqrt and qmvn_div.
//
//   channel  | direction | words
//   in_ch    | sink      | vertex load, quad load, normal query
//   out_ch   | source    | one word per query
//   cfg_ch   | sink      | quad_count, always ready
//
// A vertex load is written straight into the vertex memory. A quad load does
// three memory reads and six products through the shared multiplier.
// A query walks the quad table, takes absolute values, shifts the magnitudes
// until the largest has its top bit at bit 29, sums the three squares, takes
// the root and divides each magnitude by that length.
// Reset clears control state only; memories hold garbage until written.
// A finished query waits in the output register while new words are taken.
module quad_mesh_vertex_normals (
  input  logic             clk,
  input  logic             rst_n,
  qmvn_in_if.sink          in_ch,
  qmvn_out_if.source       out_ch,
  qmvn_cfg_if.sink         cfg_ch
);

  qmvn_pkg::state_t state_r, state_nxt;

  logic [qmvn_pkg::CntW-1:0] quad_count_r;
  logic [2:0]                cnt_r;
  logic [qmvn_pkg::IdxW-1:0] idx_r;
  logic [4*qmvn_pkg::IdxW-1:0] corners_r;
  logic signed [16:0]        da_r [3];
  logic signed [16:0]        db_r [3];
  logic [47:0]               p0_r, p1_r;
  logic signed [qmvn_pkg::FnW-1:0] fn_r [3];
  logic [qmvn_pkg::CntW-1:0] q_r;
  logic                      rd_vld_r;
  logic signed [qmvn_pkg::SumW-1:0] sum_r [3];
  logic [qmvn_pkg::SumW-1:0] mag_r [3];
  logic [qmvn_pkg::SumW-1:0] mx_r;
  logic                      neg_r [3];
  logic [qmvn_pkg::ProdW-1:0] sq_r;
  logic [qmvn_pkg::RootW-1:0] len_r;
  logic [qmvn_pkg::NrmW-1:0] nrm_r [3];

  logic [47:0]  vpos_mem [1024];
  logic [47:0]  vpos_rd_r;
  logic [qmvn_pkg::IdxW-1:0] vpos_raddr;
  logic [4*qmvn_pkg::IdxW-1:0] qc_mem [1024];
  logic [3*qmvn_pkg::FnW-1:0]  qn_mem [1024];
  logic [4*qmvn_pkg::IdxW-1:0] qc_rd_r;
  logic [3*qmvn_pkg::FnW-1:0]  qn_rd_r;

  logic out_valid_r;
  logic [qmvn_pkg::IdxW-1:0] out_idx_r;
  logic [qmvn_pkg::NrmW-1:0] out_x_r, out_y_r, out_z_r;
  logic out_zero_r;

  logic in_acc, walk_issue, out_load;
  logic [qmvn_pkg::CntW-1:0] n_quads;
  logic signed [qmvn_pkg::MulW-1:0] mul_a, mul_b;
  logic signed [qmvn_pkg::ProdW-1:0] mul_p;
  logic sqrt_start, sqrt_done, div_start, div_done;
  logic [qmvn_pkg::RootW-1:0] sqrt_root;
  logic [qmvn_pkg::QuotW-1:0] div_q;
  logic [qmvn_pkg::NumW-1:0] div_num;
  logic [qmvn_pkg::DenW-1:0] div_den;
  logic [1:0] comp;
  logic [2:0] match_cnt;
  logic [qmvn_pkg::QuotW-1:0] r_clamp;

  assign in_ch.ready  = (state_r == qmvn_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign n_quads = (quad_count_r > qmvn_pkg::CntW'(qmvn_pkg::MaxQuads)) ?
                   qmvn_pkg::CntW'(qmvn_pkg::MaxQuads) : quad_count_r;
  assign walk_issue = (state_r == qmvn_pkg::ST_WALK) && (q_r < n_quads);
  assign out_load   = (state_r == qmvn_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);
  assign comp       = cnt_r[1:0];

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_index = out_idx_r;
  assign out_ch.normal_x     = out_x_r;
  assign out_ch.normal_y     = out_y_r;
  assign out_ch.normal_z     = out_z_r;
  assign out_ch.zero_length  = out_zero_r;

  always_comb begin
    case (cnt_r)
      3'd0: vpos_raddr = corners_r[4*qmvn_pkg::IdxW-1 -: qmvn_pkg::IdxW];
      3'd1: vpos_raddr = corners_r[3*qmvn_pkg::IdxW-1 -: qmvn_pkg::IdxW];
      default: vpos_raddr = corners_r[qmvn_pkg::IdxW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.operation == qmvn_pkg::OP_LOAD_VERTEX) begin
      vpos_mem[in_ch.index] <= {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
    end
    vpos_rd_r <= vpos_mem[vpos_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == qmvn_pkg::ST_QWR) begin
      qc_mem[idx_r] <= corners_r;
      qn_mem[idx_r] <= {fn_r[0], fn_r[1], fn_r[2]};
    end
    qc_rd_r <= qc_mem[q_r[qmvn_pkg::IdxW-1:0]];
    qn_rd_r <= qn_mem[q_r[qmvn_pkg::IdxW-1:0]];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == qmvn_pkg::ST_XMUL) begin
      case (cnt_r)
        3'd0: begin mul_a = qmvn_pkg::MulW'(da_r[1]); mul_b = qmvn_pkg::MulW'(db_r[2]); end
        3'd1: begin mul_a = qmvn_pkg::MulW'(da_r[2]); mul_b = qmvn_pkg::MulW'(db_r[1]); end
        3'd2: begin mul_a = qmvn_pkg::MulW'(da_r[2]); mul_b = qmvn_pkg::MulW'(db_r[0]); end
        3'd3: begin mul_a = qmvn_pkg::MulW'(da_r[0]); mul_b = qmvn_pkg::MulW'(db_r[2]); end
        3'd4: begin mul_a = qmvn_pkg::MulW'(da_r[0]); mul_b = qmvn_pkg::MulW'(db_r[1]); end
        3'd5: begin mul_a = qmvn_pkg::MulW'(da_r[1]); mul_b = qmvn_pkg::MulW'(db_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == qmvn_pkg::ST_SQ && cnt_r < 3'd3) begin
      mul_a = {1'b0, mag_r[comp][29:0]};
      mul_b = {1'b0, mag_r[comp][29:0]};
    end
  end

  qmvn_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  assign sqrt_start = (state_r == qmvn_pkg::ST_SQRT_GO);
  qmvn_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(sq_r),
                    .done_r(sqrt_done), .root_r(sqrt_root));

  assign div_start = (state_r == qmvn_pkg::ST_DIV_GO);
  assign div_num   = {1'b0, mag_r[comp][29:0], 15'd0} + qmvn_pkg::NumW'(len_r);
  assign div_den   = {len_r, 1'b0};
  qmvn_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
                  .den(div_den), .done_r(div_done), .quot_r(div_q));

  assign r_clamp = (div_q > qmvn_pkg::QuotW'(qmvn_pkg::UNIT_ONE)) ?
                   qmvn_pkg::QuotW'(qmvn_pkg::UNIT_ONE) : div_q;

  always_comb begin
    match_cnt = 3'(qc_rd_r[4*qmvn_pkg::IdxW-1 -: qmvn_pkg::IdxW] == idx_r)
              + 3'(qc_rd_r[3*qmvn_pkg::IdxW-1 -: qmvn_pkg::IdxW] == idx_r)
              + 3'(qc_rd_r[2*qmvn_pkg::IdxW-1 -: qmvn_pkg::IdxW] == idx_r)
              + 3'(qc_rd_r[qmvn_pkg::IdxW-1:0] == idx_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qmvn_pkg::ST_IDLE: begin
        if (in_acc && in_ch.operation == qmvn_pkg::OP_LOAD_QUAD) begin
          state_nxt = qmvn_pkg::ST_VRD;
        end else if (in_acc && in_ch.operation == qmvn_pkg::OP_QUERY) begin
          state_nxt = qmvn_pkg::ST_WALK;
        end
      end
      qmvn_pkg::ST_VRD: if (cnt_r == 3'd3) state_nxt = qmvn_pkg::ST_XMUL;
      qmvn_pkg::ST_XMUL: if (cnt_r == 3'd6) state_nxt = qmvn_pkg::ST_QWR;
      qmvn_pkg::ST_QWR: state_nxt = qmvn_pkg::ST_IDLE;
      qmvn_pkg::ST_WALK: if (!walk_issue && !rd_vld_r) state_nxt = qmvn_pkg::ST_ABS;
      qmvn_pkg::ST_ABS: state_nxt = qmvn_pkg::ST_SHIFT;
      qmvn_pkg::ST_SHIFT: begin
        if (mx_r == '0) begin
          state_nxt = qmvn_pkg::ST_DONE;
        end else if (mx_r[qmvn_pkg::SumW-1:30] == '0 && mx_r[29]) begin
          state_nxt = qmvn_pkg::ST_SQ;
        end
      end
      qmvn_pkg::ST_SQ: if (cnt_r == 3'd3) state_nxt = qmvn_pkg::ST_SQRT_GO;
      qmvn_pkg::ST_SQRT_GO: state_nxt = qmvn_pkg::ST_SQRT_WAIT;
      qmvn_pkg::ST_SQRT_WAIT: if (sqrt_done) state_nxt = qmvn_pkg::ST_DIV_GO;
      qmvn_pkg::ST_DIV_GO: state_nxt = qmvn_pkg::ST_DIV_WAIT;
      qmvn_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (cnt_r == 3'd2) ? qmvn_pkg::ST_DONE : qmvn_pkg::ST_DIV_GO;
        end
      end
      qmvn_pkg::ST_DONE: if (out_load) state_nxt = qmvn_pkg::ST_IDLE;
      default: state_nxt = qmvn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qmvn_pkg::ST_IDLE;
      quad_count_r <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= walk_issue;
      if (cfg_ch.valid) begin
        quad_count_r <= cfg_ch.quad_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      qmvn_pkg::ST_IDLE: begin
        cnt_r     <= 3'd0;
        q_r       <= '0;
        idx_r     <= in_ch.index;
        corners_r <= {in_ch.corner_a, in_ch.corner_b, in_ch.corner_c, in_ch.corner_d};
        for (int k = 0; k < 3; k++) begin
          sum_r[k] <= '0;
        end
      end
      qmvn_pkg::ST_VRD: begin
        cnt_r <= (cnt_r == 3'd3) ? 3'd0 : cnt_r + 3'd1;
        if (cnt_r == 3'd1) p0_r <= vpos_rd_r;
        if (cnt_r == 3'd2) p1_r <= vpos_rd_r;
        if (cnt_r == 3'd3) begin
          for (int k = 0; k < 3; k++) begin
            da_r[k] <= 17'($signed(p1_r[47-16*k -: 16])) - 17'($signed(p0_r[47-16*k -: 16]));
            db_r[k] <= 17'($signed(vpos_rd_r[47-16*k -: 16]))
                     - 17'($signed(p0_r[47-16*k -: 16]));
          end
        end
      end
      qmvn_pkg::ST_XMUL: begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r != 3'd0) begin
          if (cnt_r[0]) begin
            fn_r[cnt_r[2:1]] <= mul_p[qmvn_pkg::FnW-1:0];
          end else begin
            fn_r[2'(cnt_r[2:1] - 2'd1)] <= fn_r[2'(cnt_r[2:1] - 2'd1)]
                                         - mul_p[qmvn_pkg::FnW-1:0];
          end
        end
      end
      qmvn_pkg::ST_WALK: begin
        if (walk_issue) q_r <= q_r + qmvn_pkg::CntW'(1);
        if (rd_vld_r) begin
          for (int k = 0; k < 3; k++) begin
            sum_r[k] <= sum_r[k]
              + qmvn_pkg::SumW'($signed(qn_rd_r[3*qmvn_pkg::FnW-1-qmvn_pkg::FnW*k -:
                                                qmvn_pkg::FnW])
                                * $signed({1'b0, match_cnt}));
          end
        end
      end
      qmvn_pkg::ST_ABS: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= sum_r[k][qmvn_pkg::SumW-1];
          mag_r[k] <= sum_r[k][qmvn_pkg::SumW-1] ? -sum_r[k] : sum_r[k];
        end
      end
      qmvn_pkg::ST_SHIFT: begin
        cnt_r <= 3'd0;
        sq_r  <= '0;
        if (mx_r[qmvn_pkg::SumW-1:30] != '0) begin
          mx_r <= mx_r >> 1;
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
        end else if (!mx_r[29] && mx_r != '0) begin
          mx_r <= mx_r << 1;
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
        end
      end
      qmvn_pkg::ST_SQ: begin
        cnt_r <= (cnt_r == 3'd3) ? 3'd0 : cnt_r + 3'd1;
        if (cnt_r != 3'd0) sq_r <= sq_r + mul_p;
      end
      qmvn_pkg::ST_SQRT_WAIT: begin
        if (sqrt_done) len_r <= sqrt_root;
      end
      qmvn_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          nrm_r[comp] <= neg_r[comp] ? -qmvn_pkg::NrmW'(r_clamp) : qmvn_pkg::NrmW'(r_clamp);
          cnt_r <= cnt_r + 3'd1;
        end
      end
      qmvn_pkg::ST_DONE: begin
        if (out_load) begin
          out_idx_r  <= idx_r;
          out_zero_r <= (mx_r == '0);
          out_x_r    <= (mx_r == '0) ? '0 : nrm_r[0];
          out_y_r    <= (mx_r == '0) ? '0 : nrm_r[1];
          out_z_r    <= (mx_r == '0) ? '0 : nrm_r[2];
        end
      end
      default: begin
      end
    endcase
    if (state_r == qmvn_pkg::ST_ABS) begin
      mx_r <= ((sum_r[0][qmvn_pkg::SumW-1] ? -sum_r[0] : sum_r[0])
               > (sum_r[1][qmvn_pkg::SumW-1] ? -sum_r[1] : sum_r[1]))
              ? ((((sum_r[0][qmvn_pkg::SumW-1] ? -sum_r[0] : sum_r[0])
                 > (sum_r[2][qmvn_pkg::SumW-1] ? -sum_r[2] : sum_r[2])))
                 ? (sum_r[0][qmvn_pkg::SumW-1] ? -sum_r[0] : sum_r[0])
                 : (sum_r[2][qmvn_pkg::SumW-1] ? -sum_r[2] : sum_r[2]))
              : ((((sum_r[1][qmvn_pkg::SumW-1] ? -sum_r[1] : sum_r[1])
                 > (sum_r[2][qmvn_pkg::SumW-1] ? -sum_r[2] : sum_r[2])))
                 ? (sum_r[1][qmvn_pkg::SumW-1] ? -sum_r[1] : sum_r[1])
                 : (sum_r[2][qmvn_pkg::SumW-1] ? -sum_r[2] : sum_r[2]));
    end
  end

endmodule
